// ===== rtl/stream_find_and_replace_top_macros.svh =====
// assertion macros shared by the find-and-replace rtl
`ifndef STREAM_FIND_AND_REPLACE_TOP_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define SFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SFR_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
// shared types and constants of the stream find-and-replace block
package sfr_pkg;

  localparam int TEXT_BYTES            = 8;
  localparam int TEXT_W                = 8 * TEXT_BYTES;
  localparam int CNT_W                 = 4;
  localparam int CFG_IDX_W             = 8;
  localparam int DEF_MAX_PATTERN_BYTES = 8;
  localparam int DEF_QUEUE_DEPTH       = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PATTERN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LENGTH       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_TEXT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    logic [TEXT_W-1:0] match_pattern;
    logic [CNT_W-1:0]  match_length;
    logic [TEXT_W-1:0] replacement_text;
    logic [CNT_W-1:0]  replacement_length;
  } sfr_cfg_t;

  // one decided run of output bytes, byte 0 in the low bits
  typedef struct packed {
    logic [TEXT_W-1:0] text_bytes;
    logic [CNT_W-1:0]  count;
    logic              marker;
    logic              last;
  } cmd_t;

endpackage

// ===== rtl/stream_find_and_replace_top.sv =====
// top level of the stream find-and-replace block
// Streaming find-and-replace: text enters one byte per beat on the in_ channel and
// every non-overlapping occurrence of the configured pattern (1 to 8 bytes, scanned
// left to right, greedy) leaves as the replacement text (0 to 8 bytes); other bytes
// pass unchanged. The input side takes one byte every cycle while in_ready is high,
// and the output side moves one byte every cycle while out_ready is high. An input
// byte yields one beat if plain, the replacement length for a match, and
// up to the pattern length on the last byte of a text, which flushes the window or
// yields one empty end marker. A queue of QUEUE_DEPTH decided runs sits between the
// front end and the output stage; in_ready drops only when that queue is full, so
// the output beat rate of the back end sets the sustained throughput. With the queue
// empty and the output stage idle, the first beat caused by an accepted byte is
// registered in the queue and then in the output stage before it is offered. Writes
// to the cfg_ port are always accepted; writing match_length drops undecided bytes.
module stream_find_and_replace_top
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // text input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // text output beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEXT_W-1:0]    cfg_data
);

  // configuration registers
  logic [TEXT_W-1:0] match_pattern_r;
  logic [CNT_W-1:0]  match_length_r;
  logic [TEXT_W-1:0] replacement_text_r;
  logic [CNT_W-1:0]  replacement_length_r;
  logic              cfg_write;
  logic              window_clear;
  sfr_cfg_t          cfg;

  // front to queue and queue to back
  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  // register writes are always taken
  assign cfg_ready    = 1'b1;
  assign cfg_write    = cfg_valid && cfg_ready;
  // a new pattern length invalidates the window contents
  assign window_clear = cfg_write && (cfg_index == CFG_MATCH_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pattern_r      <= '0;
      match_length_r       <= CNT_W'(1);
      replacement_text_r   <= '0;
      replacement_length_r <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MATCH_PATTERN:      match_pattern_r      <= cfg_data;
        CFG_MATCH_LENGTH:       match_length_r       <= cfg_data[CNT_W-1:0];
        CFG_REPLACEMENT_TEXT:   replacement_text_r   <= cfg_data;
        CFG_REPLACEMENT_LENGTH: replacement_length_r <= cfg_data[CNT_W-1:0];
        default: begin
          // unknown index, write ignored
        end
      endcase
    end
  end

  assign cfg.match_pattern      = match_pattern_r;
  assign cfg.match_length       = match_length_r;
  assign cfg.replacement_text   = replacement_text_r;
  assign cfg.replacement_length = replacement_length_r;

  // window and compare; decides at most one run per input byte
  sfr_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .clear    (window_clear),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(front_valid),
    .cmd      (front_cmd),
    .cmd_ready(front_ready)
  );

  // decouples input acceptance from output expansion
  sfr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_data  (front_cmd),
    .out_valid(back_valid),
    .out_ready(back_ready),
    .out_data (back_cmd)
  );

  // plays each run out byte by byte
  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(back_valid),
    .cmd_ready(back_ready),
    .cmd      (back_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/sfr_front.sv =====
// front end: window, pattern compare and run classification
`include "stream_find_and_replace_top_macros.svh"

module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sfr_cfg_t cfg,
  input  logic     clear,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_ready
);

  localparam int IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int FW = $clog2(MAX_PATTERN_BYTES + 1);

  logic [IW-1:0]                fill_r;
  logic [IW-1:0]                fill_nxt;
  logic [7:0]                   window_r [MAX_PATTERN_BYTES];
  logic [7:0]                   win_push [MAX_PATTERN_BYTES];
  logic [TEXT_W-1:0]            win_flat;
  logic [MAX_PATTERN_BYTES-1:0] lane_ok;
  logic [FW-1:0]                plen;
  logic [FW-1:0]                fill_push;
  logic [CNT_W-1:0]             rlen;
  logic [CNT_W-1:0]             count;
  logic                         full;
  logic                         hit;
  logic                         accept;

  always_comb begin
    if (cfg.match_length == '0) begin
      plen = FW'(1);
    end else if (cfg.match_length > CNT_W'(MAX_PATTERN_BYTES)) begin
      plen = FW'(MAX_PATTERN_BYTES);
    end else begin
      plen = FW'(cfg.match_length);
    end

    if (cfg.replacement_length > CNT_W'(TEXT_BYTES)) begin
      rlen = CNT_W'(TEXT_BYTES);
    end else begin
      rlen = cfg.replacement_length;
    end

    fill_push = FW'(fill_r) + FW'(1);
    win_flat  = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      win_push[i]       = (IW'(i) == fill_r) ? in_data.in_byte : window_r[i];
      win_flat[8*i +: 8] = win_push[i];
      lane_ok[i]        = (FW'(i) >= plen) || (win_push[i] == cfg.match_pattern[8*i +: 8]);
    end

    full = (fill_push == plen);
    hit  = full && (&lane_ok);

    // last byte without a hit flushes the whole window, oldest byte first
    priority if (hit) begin
      count = rlen;
    end else if (in_data.is_last) begin
      count = CNT_W'(fill_push);
    end else if (full) begin
      count = CNT_W'(1);
    end else begin
      count = '0;
    end
  end

  assign cmd.text_bytes = hit ? cfg.replacement_text : win_flat;
  assign cmd.count      = count;
  assign cmd.marker     = in_data.is_last && (count == '0);
  assign cmd.last       = in_data.is_last;

  assign cmd_valid = in_valid && ((count != '0) || in_data.is_last);
  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    fill_nxt = fill_r;
    if (clear) begin
      fill_nxt = '0;
    end else if (accept) begin
      if (in_data.is_last || hit) begin
        fill_nxt = '0;
      end else if (!full) begin
        fill_nxt = fill_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // on a miss with a full window the oldest byte leaves and the rest move down
  always_ff @(posedge clk) begin
    if (accept) begin
      if (full && !hit) begin
        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
          window_r[i] <= win_push[i+1];
        end
      end else begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
          window_r[i] <= win_push[i];
        end
      end
    end
  end

  `SFR_ASSERT(a_fill_below_plen, FW'(fill_r) < plen, "window holds a full pattern")

endmodule

// ===== rtl/sfr_queue.sv =====
// small run queue between front and back end
`include "stream_find_and_replace_top_macros.svh"

module sfr_queue
  import sfr_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  localparam int QW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r;
  logic [QW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          push;
  logic          pop;

  assign in_ready  = (count_r != CW'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(DEPTH - 1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(DEPTH - 1)) ? '0 : rd_ptr_r + QW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

  `SFR_ASSERT_NEVER(a_count_overflow, count_r > CW'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/sfr_back.sv =====
// back end: expands runs into output beats, one byte per beat
`include "stream_find_and_replace_top_macros.svh"

module sfr_back
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic              cur_valid_r;
  logic              cur_valid_nxt;
  logic [TEXT_W-1:0] bytes_r;
  logic [TEXT_W-1:0] bytes_nxt;
  logic [CNT_W-1:0]  remain_r;
  logic [CNT_W-1:0]  remain_nxt;
  logic              marker_r;
  logic              marker_nxt;
  logic              last_r;
  logic              last_nxt;
  logic              last_beat;
  logic              take;

  assign last_beat = (remain_r == CNT_W'(1));
  assign take      = cur_valid_r && out_ready;
  assign cmd_ready = !cur_valid_r || (take && last_beat);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    bytes_nxt     = bytes_r;
    remain_nxt    = remain_r;
    marker_nxt    = marker_r;
    last_nxt      = last_r;
    if (cmd_valid && cmd_ready) begin
      cur_valid_nxt = 1'b1;
      bytes_nxt     = cmd.text_bytes;
      remain_nxt    = cmd.marker ? CNT_W'(1) : cmd.count;
      marker_nxt    = cmd.marker;
      last_nxt      = cmd.last;
    end else if (take) begin
      if (last_beat) begin
        cur_valid_nxt = 1'b0;
      end else begin
        bytes_nxt  = bytes_r >> 8;
        remain_nxt = remain_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    remain_r <= remain_nxt;
    marker_r <= marker_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid           = cur_valid_r;
  assign out_data.out_byte   = marker_r ? 8'h00 : bytes_r[7:0];
  assign out_data.byte_valid = !marker_r;
  assign out_data.run_last   = last_beat;
  assign out_data.text_end   = last_r && last_beat;

  `SFR_ASSERT(a_run_no_gap, out_valid && out_ready && !out_data.run_last |=> out_valid, "run broken")
  `SFR_ASSERT(a_marker_ends_text, out_valid && !out_data.byte_valid |-> out_data.run_last && out_data.text_end, "end marker not closing text")

endmodule
